@@ sv/rmep_pkg.sv @@
// Package: shared types, constants and CORDIC helpers for the pose converter.
`default_nettype none
package rmep_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_STEPS        = 24;

  // Datapath widths: vector components and angle accumulator
  localparam int VW = 36;
  localparam int AW = 26;
  localparam int PW = 24;
  localparam int MW = 34;

  localparam logic signed [AW-1:0] ANG_180 = 26'sd5898240;
  localparam logic [29:0]          INV_GAIN = 30'd652032874;
  localparam logic signed [AW-1:0] LIM_WIDE = 26'sd23040;
  localparam logic signed [AW-1:0] LIM_PITCH = 26'sd11520;

  // Config register indexes
  localparam int CFG_IW = 8;
  localparam logic [CFG_IW-1:0] REG_X_OFFSET = 8'd0;
  localparam logic [CFG_IW-1:0] REG_Z_OFFSET = 8'd1;

  localparam logic signed [PW-1:0] X_OFFSET_RST = -24'sd45875;
  localparam logic signed [PW-1:0] Z_OFFSET_RST = -24'sd16384;

  localparam int QUEUE_DEPTH = 4;
  localparam int QAW = 2;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [AW-1:0] z;
    logic                 hold;
  } cordic_t;

  typedef struct packed {
    logic                 pose_valid;
    logic signed [PW-1:0] ox;
    logic signed [PW-1:0] py;
    logic signed [PW-1:0] oz;
    cordic_t              roll;
    cordic_t              yaw;
    cordic_t              pit;
  } pose_t;

  // atan(2^-i) in 1/32768 degree
  function automatic logic signed [AW-1:0] atan_lut(input int unsigned i);
    logic signed [AW-1:0] v;
    case (i)
      0:  v = 26'sd1474560;
      1:  v = 26'sd870484;
      2:  v = 26'sd459940;
      3:  v = 26'sd233473;
      4:  v = 26'sd117189;
      5:  v = 26'sd58652;
      6:  v = 26'sd29333;
      7:  v = 26'sd14667;
      8:  v = 26'sd7334;
      9:  v = 26'sd3667;
      10: v = 26'sd1833;
      11: v = 26'sd917;
      12: v = 26'sd458;
      13: v = 26'sd229;
      14: v = 26'sd115;
      15: v = 26'sd57;
      16: v = 26'sd29;
      17: v = 26'sd14;
      18: v = 26'sd7;
      19: v = 26'sd4;
      20: v = 26'sd2;
      21: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Set up a vector for vectoring mode: zero-y and left-half-plane handling
  function automatic cordic_t cordic_init(input logic signed [VW-1:0] y,
                                          input logic signed [VW-1:0] x);
    cordic_t r;
    r.x = x;
    r.y = y;
    r.z = '0;
    r.hold = 1'b0;
    if (y == '0) begin
      r.hold = 1'b1;
      if (x < 0) begin
        r.x = -x;
        r.z = ANG_180;
      end
    end else if (x < 0) begin
      r.x = -x;
      r.y = -y;
      r.z = (y > 0) ? ANG_180 : -ANG_180;
    end
    return r;
  endfunction

  // One micro-rotation; floor shifts
  function automatic cordic_t cordic_step(input cordic_t s, input int unsigned i);
    cordic_t r;
    logic signed [VW-1:0] xs;
    logic signed [VW-1:0] ys;
    r = s;
    xs = s.x >>> i;
    ys = s.y >>> i;
    if (!s.hold) begin
      if (s.y >= 0) begin
        r.x = s.x + ys;
        r.y = s.y - xs;
        r.z = s.z + atan_lut(i);
      end else begin
        r.x = s.x - ys;
        r.y = s.y + xs;
        r.z = s.z - atan_lut(i);
      end
    end
    return r;
  endfunction

  // Round to 1/128 degree and clamp to +-lim
  function automatic logic signed [15:0] angle_out(input logic signed [AW-1:0] z,
                                                   input logic signed [AW-1:0] lim);
    logic signed [AW-1:0] t;
    t = (z + 26'sd128) >>> 8;
    if (t > lim) t = lim;
    else if (t < -lim) t = -lim;
    return t[15:0];
  endfunction

endpackage
`default_nettype wire

@@ sv/rotation_matrix_to_euler_pose.sv @@
// Top level: rotation matrix and position to Euler pose converter.
// Accepts one pose request per clock and delivers one result per clock unless
// in_stall (queue full) or result_stall on a held result holds the flow. The
// roll and yaw CORDICs take one stage per iteration, the hypot gain correction
// one stage, the pitch CORDIC (which needs the roll magnitude) another
// CORDIC_STEPS stages, plus the queue head and output registers. A four-entry
// queue separates input classification from the CORDIC pipe; in_stall rises only when it is full.
// The config port never stalls (cfg_ready is always high); write only when idle.
`default_nettype none
module rotation_matrix_to_euler_pose #(
  parameter int CORDIC_STEPS = rmep_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [rmep_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [23:0]                 cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        pose_valid,
  input  wire logic signed [15:0]          r00,
  input  wire logic signed [15:0]          r10,
  input  wire logic signed [15:0]          r20,
  input  wire logic signed [15:0]          r21,
  input  wire logic signed [15:0]          r22,
  input  wire logic signed [23:0]          pos_x,
  input  wire logic signed [23:0]          pos_y,
  input  wire logic signed [23:0]          pos_z,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output logic                             out_valid,
  output logic signed [23:0]               out_x,
  output logic signed [23:0]               out_y,
  output logic signed [23:0]               out_z,
  output logic signed [15:0]               yaw_angle,
  output logic signed [14:0]               pitch_angle,
  output logic signed [15:0]               roll_angle
);

  rmep_pkg::pose_t entry;
  rmep_pkg::pose_t head;
  logic            full;
  logic            empty;
  logic            pop;
  logic            push;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign push      = in_valid && !full;

  rmep_front u_front (
    .clk, .rst, .cfg_valid, .cfg_index, .cfg_data,
    .pose_valid, .r00, .r10, .r20, .r21, .r22, .pos_x, .pos_y, .pos_z,
    .entry
  );

  rmep_queue u_queue (
    .clk, .rst, .push, .wdata(entry), .pop, .rdata(head), .full, .empty
  );

  rmep_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst, .head, .empty, .pop, .result_valid, .result_stall,
    .out_valid, .out_x, .out_y, .out_z, .yaw_angle, .pitch_angle, .roll_angle
  );

endmodule
`default_nettype wire

@@ sv/rmep_front.sv @@
// Front end: config registers, pose classification and position math.
`default_nettype none
module rmep_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  input  wire logic [rmep_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [23:0]                 cfg_data,
  input  wire logic                        pose_valid,
  input  wire logic signed [15:0]          r00,
  input  wire logic signed [15:0]          r10,
  input  wire logic signed [15:0]          r20,
  input  wire logic signed [15:0]          r21,
  input  wire logic signed [15:0]          r22,
  input  wire logic signed [23:0]          pos_x,
  input  wire logic signed [23:0]          pos_y,
  input  wire logic signed [23:0]          pos_z,
  output rmep_pkg::pose_t                  entry
);

  logic signed [23:0] x_offset;
  logic signed [23:0] z_offset;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset <= rmep_pkg::X_OFFSET_RST;
      z_offset <= rmep_pkg::Z_OFFSET_RST;
    end else if (cfg_valid) begin
      if (cfg_index == rmep_pkg::REG_X_OFFSET) x_offset <= cfg_data;
      else if (cfg_index == rmep_pkg::REG_Z_OFFSET) z_offset <= cfg_data;
    end
  end

  function automatic logic signed [rmep_pkg::VW-1:0] widen(input logic signed [15:0] r);
    return {{(rmep_pkg::VW-32){r[15]}}, r, 16'h0000};
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    if (v > 26'sd8388607) return 24'sh7FFFFF;
    if (v < -26'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  logic signed [25:0] sum_x;
  logic signed [25:0] sum_z;

  // Classify and build the queue entry; invalid poses are built the same way and carry the flag
  always_comb begin
    sum_x = -{{2{pos_x[23]}}, pos_x} + {{2{x_offset[23]}}, x_offset};
    sum_z = {{2{pos_z[23]}}, pos_z} + {{2{z_offset[23]}}, z_offset};
    entry.pose_valid = pose_valid;
    entry.ox   = sat24(sum_x);
    entry.py   = pos_y;
    entry.oz   = sat24(sum_z);
    entry.roll = rmep_pkg::cordic_init(widen(r21), widen(r22));
    entry.yaw  = rmep_pkg::cordic_init(widen(r10), widen(r00));
    entry.pit.x = '0;
    entry.pit.y = -widen(r20);
    entry.pit.z = '0;
    entry.pit.hold = 1'b0;
  end

endmodule
`default_nettype wire

@@ sv/rmep_queue.sv @@
// Short request queue between front end and CORDIC back end.
`default_nettype none
module rmep_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  rmep_pkg::pose_t      wdata,
  input  wire logic            pop,
  output rmep_pkg::pose_t      rdata,
  output logic                 full,
  output logic                 empty
);

  rmep_pkg::pose_t        mem [rmep_pkg::QUEUE_DEPTH];
  logic [rmep_pkg::QAW-1:0] wptr;
  logic [rmep_pkg::QAW-1:0] rptr;
  logic [rmep_pkg::QAW:0]   count;

  assign full  = (count == (rmep_pkg::QAW+1)'(rmep_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (rmep_pkg::QAW+1)'(push) - (rmep_pkg::QAW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

@@ sv/rmep_back.sv @@
// Back end: pipelined CORDIC (roll/yaw, gain correction, pitch) and output register.
`default_nettype none
module rmep_back #(
  parameter int CORDIC_STEPS = rmep_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  rmep_pkg::pose_t    head,
  input  wire logic          empty,
  output logic               pop,
  output logic               result_valid,
  input  wire logic          result_stall,
  output logic               out_valid,
  output logic signed [23:0] out_x,
  output logic signed [23:0] out_y,
  output logic signed [23:0] out_z,
  output logic signed [15:0] yaw_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] roll_angle
);

  localparam int LAST = 2 * CORDIC_STEPS + 1;

  rmep_pkg::pose_t stage [LAST+1];
  logic [LAST:0]   vld;
  logic            en;

  // Whole pipe advances unless a finished result is held
  assign en  = !(result_valid && result_stall);
  assign pop = en && !empty;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAST-1:0], !empty};
  end

  always_ff @(posedge clk) begin
    if (en) stage[0] <= head;
  end

  // Stage 1..N roll/yaw steps, N+1 gain correction, N+2..2N+1 pitch steps
  for (genvar k = 1; k <= LAST; k++) begin : g_stage
    rmep_pkg::pose_t nxt;
    if (k <= CORDIC_STEPS) begin : g_ry
      always_comb begin
        nxt = stage[k-1];
        nxt.roll = rmep_pkg::cordic_step(stage[k-1].roll, k - 1);
        nxt.yaw  = rmep_pkg::cordic_step(stage[k-1].yaw, k - 1);
      end
    end else if (k == CORDIC_STEPS + 1) begin : g_gain
      logic [rmep_pkg::MW-1:0] mag;
      logic [63:0]             prod;
      always_comb begin
        nxt = stage[k-1];
        mag = stage[k-1].roll.x[rmep_pkg::VW-1] ? rmep_pkg::MW'(-stage[k-1].roll.x)
                                                : rmep_pkg::MW'(stage[k-1].roll.x);
        prod = 64'(mag) * 64'(rmep_pkg::INV_GAIN);
        nxt.pit.x = rmep_pkg::VW'(prod[63:30]);
        nxt.pit.z = '0;
        nxt.pit.hold = (stage[k-1].pit.y == '0);
      end
    end else begin : g_pitch
      always_comb begin
        nxt = stage[k-1];
        nxt.pit = rmep_pkg::cordic_step(stage[k-1].pit, k - CORDIC_STEPS - 2);
      end
    end
    always_ff @(posedge clk) begin
      if (en) stage[k] <= nxt;
    end
  end

  // Output register: rounding, clamps, zero fields for invalid poses
  rmep_pkg::pose_t    fin;
  logic signed [15:0] roll_c;
  logic signed [15:0] pitch_c;
  assign fin     = stage[LAST];
  assign roll_c  = rmep_pkg::angle_out(fin.roll.z, rmep_pkg::LIM_WIDE);
  assign pitch_c = rmep_pkg::angle_out(fin.pit.z, rmep_pkg::LIM_PITCH);

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (en) result_valid <= vld[LAST];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fin.pose_valid) begin
        out_valid   <= 1'b1;
        out_x       <= fin.ox;
        out_y       <= fin.py;
        out_z       <= fin.oz;
        yaw_angle   <= rmep_pkg::angle_out(fin.yaw.z, rmep_pkg::LIM_WIDE);
        pitch_angle <= pitch_c[14:0];
        roll_angle  <= -roll_c;
      end else begin
        out_valid   <= 1'b0;
        out_x       <= '0;
        out_y       <= '0;
        out_z       <= '0;
        yaw_angle   <= '0;
        pitch_angle <= '0;
        roll_angle  <= '0;
      end
    end
  end

endmodule
`default_nettype wire
